// ===== design/path_efficiency_ratio_defines.svh =====
// assertion macros for the path efficiency ratio block
`ifndef PATH_EFFICIENCY_RATIO_DEFINES_SVH
`define PATH_EFFICIENCY_RATIO_DEFINES_SVH

// checked only while out of reset
`define PER_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define PER_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/per_pkg.sv =====
// types and constants shared by the path efficiency ratio modules
package per_pkg;

	localparam int PRICE_W   = 32;
	localparam int PATH_W    = 48;
	localparam int FRAC_W    = 16;
	localparam int RATIO_W   = FRAC_W + 1;
	localparam int DIV_STEPS = RATIO_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << FRAC_W;
	localparam logic [PATH_W-1:0]  PATH_MAX  = {PATH_W{1'b1}};

	typedef struct packed {
		logic [PRICE_W-1:0] price;
		logic               missing;
		logic               last;
	} sample_t;

	typedef struct packed {
		logic [RATIO_W-1:0] ratio;
		logic               ratio_valid;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic prep;
		logic step;
		logic load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last;
		logic ok;
	} status_t;

endpackage

// ===== design/per_ctrl.sv =====
// controller: sample acceptance, divider sequencing and result register handshake
module per_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_stall,
	output logic             result_valid,
	input  logic             result_stall,
	input  per_pkg::status_t status,
	output per_pkg::cmd_t    cmd
);
	import per_pkg::*;

	typedef enum logic [1:0] {
		IDLE,
		PREP,
		DIV,
		PUSH
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             result_valid_q;

	assign sample_stall = (state_q != IDLE);
	assign result_valid = result_valid_q;

	always_comb begin
		cmd.take = sample_valid && (state_q == IDLE);
		cmd.prep = (state_q == PREP);
		cmd.step = (state_q == DIV);
		cmd.load = (state_q == PUSH) && (!result_valid_q || !result_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= IDLE;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					// an invalid result needs no division
					if (cmd.take && status.last) begin
						state_q <= status.ok ? PREP : PUSH;
					end
				end
				PREP: begin
					cnt_q   <= '0;
					state_q <= DIV;
				end
				DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= PUSH;
					end
				end
				PUSH: begin
					if (cmd.load) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

// ===== design/per_datapath.sv =====
// datapath: series state, path accumulation, restoring divider and result register
module per_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  per_pkg::sample_t sample,
	input  per_pkg::cmd_t    cmd,
	output per_pkg::status_t status,
	output per_pkg::result_t result
);
	import per_pkg::*;

	localparam int DVD_W = PATH_W + 1;

	// series state
	logic [PRICE_W-1:0] open_price_q;
	logic               open_absent_q;
	logic [PRICE_W-1:0] prev_price_q;
	logic [PATH_W-1:0]  path_q;
	logic               mid_q;

	// division operands and working registers
	logic [PRICE_W-1:0] num_q;
	logic [PATH_W-1:0]  div_q;
	logic               ok_q;
	logic [PATH_W-1:0]  rem_q;
	logic [RATIO_W-1:0] low_q;
	logic [RATIO_W-1:0] quo_q;
	result_t            result_q;

	logic [PRICE_W-1:0] diff_prev;
	logic [PRICE_W-1:0] diff_open;
	logic [PRICE_W-1:0] open_eff;
	logic               absent_eff;
	logic [PATH_W:0]    path_sum;
	logic [PATH_W-1:0]  path_next;
	logic [DVD_W-1:0]   dividend;
	logic [DVD_W-1:0]   trial;
	logic [DVD_W-1:0]   trial_sub;
	logic               trial_ge;
	logic [RATIO_W-1:0] quo_clamped;

	always_comb begin
		diff_prev = (sample.price >= prev_price_q) ? sample.price - prev_price_q
		                                           : prev_price_q - sample.price;
		path_sum  = {1'b0, path_q} + {{(PATH_W - PRICE_W + 1){1'b0}}, diff_prev};
		if (!mid_q) begin
			path_next = '0;
		end else if (sample.missing) begin
			path_next = path_q;
		end else begin
			path_next = path_sum[PATH_W] ? PATH_MAX : path_sum[PATH_W-1:0];
		end
		// a single-sample series is its own open
		open_eff   = mid_q ? open_price_q : sample.price;
		absent_eff = mid_q ? open_absent_q : sample.missing;
		diff_open  = (sample.price >= open_eff) ? sample.price - open_eff
		                                        : open_eff - sample.price;
		status.last = sample.last;
		status.ok   = !absent_eff && !sample.missing && (path_next != '0);
	end

	// rounded dividend: num * 2^16 + path / 2
	always_comb begin
		dividend = {1'b0, num_q, {FRAC_W{1'b0}}}
		         + {2'b00, div_q[PATH_W-1:1]};
		trial     = {rem_q, low_q[RATIO_W-1]};
		trial_ge  = (trial >= {1'b0, div_q});
		trial_sub = trial - {1'b0, div_q};
		quo_clamped = (quo_q > RATIO_ONE) ? RATIO_ONE : quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_price_q  <= '0;
			open_absent_q <= 1'b0;
			prev_price_q  <= '0;
			path_q        <= '0;
			mid_q         <= 1'b0;
		end else if (cmd.take) begin
			if (!mid_q) begin
				open_price_q  <= sample.price;
				open_absent_q <= sample.missing;
				prev_price_q  <= sample.price;
			end else if (!sample.missing) begin
				prev_price_q <= sample.price;
			end
			path_q <= path_next;
			mid_q  <= !sample.last;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			num_q <= diff_open;
			div_q <= path_next;
			ok_q  <= status.ok;
		end
		if (cmd.prep) begin
			// top bits are below the divisor since the quotient fits 17 bits
			rem_q <= {{(PATH_W - (DVD_W - RATIO_W)){1'b0}}, dividend[DVD_W-1:RATIO_W]};
			low_q <= dividend[RATIO_W-1:0];
			quo_q <= '0;
		end
		if (cmd.step) begin
			rem_q <= trial_ge ? trial_sub[PATH_W-1:0] : trial[PATH_W-1:0];
			low_q <= {low_q[RATIO_W-2:0], 1'b0};
			quo_q <= {quo_q[RATIO_W-2:0], trial_ge};
		end
		if (cmd.load) begin
			result_q.ratio       <= ok_q ? quo_clamped : '0;
			result_q.ratio_valid <= ok_q;
		end
	end

	assign result = result_q;

endmodule

// ===== design/path_efficiency_ratio.sv =====
// Path efficiency ratio of a price series: one sample is taken per cycle while the
// series runs, and the path length is summed with saturation at 48 bits. After the
// sample marked last, sample_stall stays high while the single restoring divider
// works out |close-open|/path in unsigned Q1.16, one quotient bit per cycle: a
// set-up state, 17 divide steps and a load of the result register when the ratio is
// valid, only the load when it is not, and the load also waits while result_stall
// holds a previous result in the output register.
module path_efficiency_ratio (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_stall,
	input  per_pkg::sample_t sample,
	output logic             result_valid,
	input  logic             result_stall,
	output per_pkg::result_t result
);
	import per_pkg::*;

	cmd_t    cmd;
	status_t status;

	per_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	per_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.cmd    (cmd),
		.status (status),
		.result (result)
	);

endmodule

// ===== design/per_checker.sv =====
// port-level checks for the path efficiency ratio block, bound to the top level
`include "path_efficiency_ratio_defines.svh"

module per_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             sample_valid,
	input logic             sample_stall,
	input per_pkg::sample_t sample,
	input logic             result_valid,
	input logic             result_stall,
	input per_pkg::result_t result
);
	import per_pkg::*;

	`PER_ASSERT(a_result_hold, result_valid && result_stall |=> $stable(result), "stalled result changed")
	`PER_ASSERT(a_last_stalls, sample_valid && !sample_stall && sample.last |=> sample_stall, "no stall after last sample")
	`PER_ASSERT(a_ratio_range, result_valid |-> (result.ratio <= RATIO_ONE), "ratio above one")
	`PER_ASSERT(a_invalid_zero, result_valid && !result.ratio_valid |-> (result.ratio == '0), "invalid ratio not zero")
	`PER_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !result_valid, "result valid in reset")

endmodule

bind path_efficiency_ratio per_checker u_per_checker (.*);

// ===== dv/tb_path_efficiency_ratio.sv =====
// self-checking testbench for the path efficiency ratio block
module tb_path_efficiency_ratio;
	timeunit 1ns;
	timeprecision 1ps;

	import per_pkg::*;

	logic    clk = 1'b0;
	logic    arst_n = 1'b1;
	logic    sample_valid = 1'b0;
	logic    sample_stall;
	sample_t sample = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	path_efficiency_ratio DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	sample_t samples_todo[$];
	result_t ratios_due[$];
	result_t want;
	int      n_total = 0;
	int      n_taken = 0;
	int      gap_left = 0;
	int      stall_left = 0;
	bit      failed = 1'b0;
	logic [15:0] cyc = '0;

	// running series as the block should see it
	logic [PRICE_W-1:0] ser_open = '0;
	logic               ser_open_missing = 1'b0;
	logic [PRICE_W-1:0] ser_prev = '0;
	logic [PATH_W-1:0]  ser_path = '0;
	logic               ser_running = 1'b0;

	function automatic bit track_sample(input sample_t s, output result_t r);
		logic [63:0] d;
		logic [63:0] sum;
		logic [63:0] num;
		logic [63:0] q;
		r = '0;
		if (!ser_running) begin
			ser_open = s.price;
			ser_open_missing = s.missing;
			ser_prev = s.price;
			ser_path = '0;
			ser_running = 1'b1;
		end else if (!s.missing) begin
			d = (s.price >= ser_prev) ? 64'(s.price - ser_prev) : 64'(ser_prev - s.price);
			sum = 64'(ser_path) + d;
			ser_path = (sum > 64'(PATH_MAX)) ? PATH_MAX : sum[PATH_W-1:0];
			ser_prev = s.price;
		end
		if (!s.last)
			return 1'b0;
		if (!ser_open_missing && !s.missing && ser_path != '0) begin
			num = (s.price >= ser_open) ? 64'(s.price - ser_open) : 64'(ser_open - s.price);
			q = ((num << FRAC_W) + 64'(ser_path >> 1)) / 64'(ser_path);
			if (q > 64'(RATIO_ONE))
				q = 64'(RATIO_ONE);
			r.ratio = q[RATIO_W-1:0];
			r.ratio_valid = 1'b1;
		end
		ser_open = '0;
		ser_open_missing = 1'b0;
		ser_prev = '0;
		ser_path = '0;
		ser_running = 1'b0;
		return 1'b1;
	endfunction

	function automatic void add_sample(logic [PRICE_W-1:0] p, logic miss, logic fin);
		sample_t s;
		s.price = p;
		s.missing = miss;
		s.last = fin;
		samples_todo.push_back(s);
		n_total++;
	endfunction

	// random series: fully random, noisy around a level, trending or nearly flat
	function automatic void add_series(int len);
		int                 style;
		logic [PRICE_W-1:0] p;
		logic               miss;
		style = $urandom_range(0, 3);
		p = $urandom;
		for (int i = 0; i < len; i++) begin
			case (style)
				0: begin
					p = $urandom;
				end
				1: begin
					p = p + $urandom_range(0, 2000) - 1000;
				end
				2: begin
					p = p + $urandom_range(0, 300);
				end
				default: begin
					if ($urandom_range(0, 2) == 0)
						p = p + $urandom_range(0, 2) - 1;
				end
			endcase
			miss = ($urandom_range(0, 9) == 0);
			add_sample(miss ? $urandom : p, miss, i == len - 1);
		end
	endfunction

	// mostly short idles, now and then a long one
	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cyc <= '0;
		else
			cyc <= cyc + 1'b1;
	end

	// sample driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			sample <= '0;
		end else begin
			if (sample_valid && !sample_stall) begin
				if (track_sample(sample, want))
					ratios_due.push_back(want);
				n_taken++;
				gap_left = (cyc[9:8] == 2'b11) ? 0 : pick_idle();
			end
			if (!sample_valid || !sample_stall) begin
				if (gap_left == 0 && samples_todo.size() != 0) begin
					sample <= samples_todo.pop_front();
					sample_valid <= 1'b1;
				end else begin
					sample_valid <= 1'b0;
					if (gap_left != 0)
						gap_left--;
				end
			end
		end
	end

	// result monitor and stall generator
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (ratios_due.size() == 0) begin
					$error("transfer with no expected ratio: ratio=%0d ratio_valid=%0b",
						result.ratio, result.ratio_valid);
					failed = 1'b1;
				end else begin
					want = ratios_due.pop_front();
					if (result.ratio !== want.ratio) begin
						$error("ratio: expected %0d, got %0d", want.ratio, result.ratio);
						failed = 1'b1;
					end
					if (result.ratio_valid !== want.ratio_valid) begin
						$error("ratio_valid: expected %0b, got %0b",
							want.ratio_valid, result.ratio_valid);
						failed = 1'b1;
					end
				end
			end
			if (stall_left != 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
				if (cyc[10:9] != 2'b00)
					stall_left = pick_idle();
			end
		end
	end

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		int rand_items;
		int len;

		// one-sample series: open is close, path is zero
		add_sample(32'd100, 1'b0, 1'b1);
		// one-sample series that is missing
		add_sample(32'hFFFF_FFFF, 1'b1, 1'b1);
		// full-scale straight move gives exactly one
		add_sample(32'h0000_0000, 1'b0, 1'b0);
		add_sample(32'hFFFF_FFFF, 1'b0, 1'b1);
		// round trip back to the open gives zero with a huge path
		add_sample(32'hFFFF_FFFF, 1'b0, 1'b0);
		add_sample(32'h0000_0000, 1'b0, 1'b0);
		add_sample(32'hFFFF_FFFF, 1'b0, 1'b1);
		// missing open
		add_sample(32'd5, 1'b1, 1'b0);
		add_sample(32'd10, 1'b0, 1'b0);
		add_sample(32'd20, 1'b0, 1'b1);
		// missing close
		add_sample(32'd10, 1'b0, 1'b0);
		add_sample(32'd20, 1'b0, 1'b0);
		add_sample(32'd30, 1'b1, 1'b1);
		// missing middle sample carries garbage price bits
		add_sample(32'd10, 1'b0, 1'b0);
		add_sample(32'hFFFF_FFFF, 1'b1, 1'b0);
		add_sample(32'd13, 1'b0, 1'b1);
		// flat series, zero path
		add_sample(32'd7, 1'b0, 1'b0);
		add_sample(32'd7, 1'b0, 1'b0);
		add_sample(32'd7, 1'b0, 1'b1);
		// exact half of one lsb, rounds up
		add_sample(32'd0, 1'b0, 1'b0);
		add_sample(32'd131073, 1'b0, 1'b0);
		add_sample(32'd2, 1'b0, 1'b1);

		rand_items = 0;
		while (rand_items < 1028) begin
			if ($urandom_range(0, 19) == 0)
				len = $urandom_range(17, 150);
			else
				len = $urandom_range(1, 12);
			add_series(len);
			rand_items += len;
		end

		// a real falling edge so the asynchronous reset is seen
		#1 arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (n_taken != n_total || ratios_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (!failed && ratios_due.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#3ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
